FILE: design/smm_pkg.sv
// shared types and constants for the small matrix multiplier
`timescale 1ns / 1ps

package smm_pkg;

  // defaults for the top-level parameters
  localparam int MAX_DIM_DEF   = 8;
  localparam int ELEM_W_DEF    = 16;

  // fixed field widths
  localparam int CFG_W         = 4;
  localparam int IDX_W         = 3;
  localparam int PRODUCT_W     = 35;
  localparam int REG_ADDR_W    = 4;
  localparam int APB_DATA_W    = 32;

  // depth of the job queue between front and back
  localparam int JOBQ_DEPTH    = 2;

  // register indexes (paddr[3:2])
  localparam logic [1:0] REG_ROWS_A     = 2'd0;
  localparam logic [1:0] REG_INNER_SIZE = 2'd1;
  localparam logic [1:0] REG_COLS_B     = 2'd2;

  // element kinds
  localparam logic KIND_A = 1'b0;
  localparam logic KIND_B = 1'b1;

  // one multiply job: clamped dimensions
  typedef struct packed {
    logic [CFG_W-1:0] m;
    logic [CFG_W-1:0] n;
    logic [CFG_W-1:0] p;
  } job_t;

endpackage

FILE: design/small_matrix_multiply.sv
// top level of the small signed matrix multiplier
`timescale 1ns / 1ps

// usage
// - item channel (item_valid, item_stall, kind, value): one element of A (kind 0) or
//   of B (kind 1) per item, row-major within its matrix; elements past a matrix's
//   size are dropped
// - loading takes one item a cycle while item_stall is low; the item that leaves both matrices full
//   starts a multiply, and item_stall stays high until the last product element
//   has been computed
// - result channel (result_valid, result_stall, row, col, product, last): every
//   element of C = A * B in row-major order, last high on the final one
// - each product element takes a start step, the walk
//   over the inner dimension reading one A and one B element a cycle from the two
//   element memories, then the multiply stage and the accumulate stage
// - a stalled result item holds in the output register; the back end waits
//   before starting the next product element, the load side is not affected
//   until the multiply finishes
// - apb port sets rows_a, inner_size, cols_b (0 acts as 1, above the maximum
//   clamps); write them only while the block is idle
// - reset (rst, synchronous): registers back to 1, load counters clear, no job
//   pending; the element memories keep their contents

module small_matrix_multiply import smm_pkg::*; #(
  parameter int MAX_DIM       = MAX_DIM_DEF,
  parameter int ELEMENT_WIDTH = ELEM_W_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  // configuration
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [REG_ADDR_W-1:0]       paddr,
  input  logic [APB_DATA_W-1:0]       pwdata,
  output logic [APB_DATA_W-1:0]       prdata,
  output logic                        pready,
  // element items
  input  logic                        item_valid,
  output logic                        item_stall,
  input  logic                        kind,
  input  logic signed [ELEMENT_WIDTH-1:0] value,
  // product items
  output logic                        result_valid,
  input  logic                        result_stall,
  output logic [IDX_W-1:0]            row,
  output logic [IDX_W-1:0]            col,
  output logic signed [PRODUCT_W-1:0] product,
  output logic                        last
);

  localparam int STORE_DEPTH = MAX_DIM * MAX_DIM;
  localparam int ADDR_W      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

  // configuration registers
  logic [CFG_W-1:0] rows_a;
  logic [CFG_W-1:0] inner_size;
  logic [CFG_W-1:0] cols_b;
  logic             cfg_write;

  // store write side (front) and read side (back)
  logic                     a_we;
  logic                     b_we;
  logic [ADDR_W-1:0]        a_waddr;
  logic [ADDR_W-1:0]        b_waddr;
  logic [ELEMENT_WIDTH-1:0] wdata;
  logic                     rd_en;
  logic [ADDR_W-1:0]        a_raddr;
  logic [ADDR_W-1:0]        b_raddr;
  logic [ELEMENT_WIDTH-1:0] a_rdata;
  logic [ELEMENT_WIDTH-1:0] b_rdata;

  // job queue
  logic job_push;
  job_t push_job;
  logic job_ready;
  logic job_pop;
  job_t pop_job;
  logic job_valid;
  logic done;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  // register writes, index taken from the word address
  always_ff @(posedge clk) begin
    if (rst) begin
      rows_a     <= CFG_W'(1);
      inner_size <= CFG_W'(1);
      cols_b     <= CFG_W'(1);
    end else if (cfg_write) begin
      unique case (paddr[3:2])
        REG_ROWS_A:     rows_a     <= pwdata[CFG_W-1:0];
        REG_INNER_SIZE: inner_size <= pwdata[CFG_W-1:0];
        REG_COLS_B:     cols_b     <= pwdata[CFG_W-1:0];
        default:        ;
      endcase
    end
  end

  // register reads return the raw written value
  always_comb begin
    unique case (paddr[3:2])
      REG_ROWS_A:     prdata = APB_DATA_W'(rows_a);
      REG_INNER_SIZE: prdata = APB_DATA_W'(inner_size);
      REG_COLS_B:     prdata = APB_DATA_W'(cols_b);
      default:        prdata = '0;
    endcase
  end

  // front: loads elements and fires a job when both matrices are full
  smm_front #(
    .MAX_DIM       (MAX_DIM),
    .ELEMENT_WIDTH (ELEMENT_WIDTH),
    .ADDR_W        (ADDR_W)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .rows_a     (rows_a),
    .inner_size (inner_size),
    .cols_b     (cols_b),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .kind       (kind),
    .value      (value),
    .a_we       (a_we),
    .b_we       (b_we),
    .a_waddr    (a_waddr),
    .b_waddr    (b_waddr),
    .wdata      (wdata),
    .job_push   (job_push),
    .job        (push_job),
    .job_ready  (job_ready),
    .done       (done)
  );

  // element stores for A and B
  smm_ram #(
    .WIDTH  (ELEMENT_WIDTH),
    .DEPTH  (STORE_DEPTH),
    .ADDR_W (ADDR_W)
  ) u_a_store (
    .clk   (clk),
    .we    (a_we),
    .waddr (a_waddr),
    .wdata (wdata),
    .re    (rd_en),
    .raddr (a_raddr),
    .rdata (a_rdata)
  );

  smm_ram #(
    .WIDTH  (ELEMENT_WIDTH),
    .DEPTH  (STORE_DEPTH),
    .ADDR_W (ADDR_W)
  ) u_b_store (
    .clk   (clk),
    .we    (b_we),
    .waddr (b_waddr),
    .wdata (wdata),
    .re    (rd_en),
    .raddr (b_raddr),
    .rdata (b_rdata)
  );

  // queue decouples the load side from the compute side
  smm_job_fifo u_jobq (
    .clk       (clk),
    .rst       (rst),
    .push      (job_push),
    .push_job  (push_job),
    .job_ready (job_ready),
    .pop       (job_pop),
    .pop_job   (pop_job),
    .job_valid (job_valid)
  );

  // back: multiply-accumulate walk and result register
  smm_back #(
    .MAX_DIM       (MAX_DIM),
    .ELEMENT_WIDTH (ELEMENT_WIDTH),
    .ADDR_W        (ADDR_W)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .job_valid    (job_valid),
    .job_in       (pop_job),
    .job_pop      (job_pop),
    .rd_en        (rd_en),
    .a_raddr      (a_raddr),
    .b_raddr      (b_raddr),
    .a_rdata      (a_rdata),
    .b_rdata      (b_rdata),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .row          (row),
    .col          (col),
    .product      (product),
    .last         (last),
    .done         (done)
  );

endmodule

FILE: design/smm_ram.sv
// generic single-write, single-read ram with registered read data
`timescale 1ns / 1ps

module smm_ram #(
  parameter int WIDTH  = 16,
  parameter int DEPTH  = 64,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: design/smm_job_fifo.sv
// short job queue between the load front and the compute back
`timescale 1ns / 1ps

module smm_job_fifo import smm_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t push_job,
  output logic job_ready,
  input  logic pop,
  output job_t pop_job,
  output logic job_valid
);

  localparam int PTR_W = (JOBQ_DEPTH > 1) ? $clog2(JOBQ_DEPTH) : 1;
  localparam int CNT_W = $clog2(JOBQ_DEPTH + 1);

  job_t             entries [JOBQ_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign job_ready = (count != CNT_W'(JOBQ_DEPTH));
  assign job_valid = (count != '0);
  assign pop_job   = entries[rd_ptr];
  assign do_push   = push && job_ready;
  assign do_pop    = pop && job_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(JOBQ_DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(JOBQ_DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_job;
    end
  end

endmodule

FILE: design/smm_front.sv
// load front: takes element items, fills the stores, fires multiply jobs
`timescale 1ns / 1ps

module smm_front import smm_pkg::*; #(
  parameter int MAX_DIM       = MAX_DIM_DEF,
  parameter int ELEMENT_WIDTH = ELEM_W_DEF,
  parameter int ADDR_W        = (MAX_DIM * MAX_DIM > 1) ? $clog2(MAX_DIM * MAX_DIM) : 1
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic [CFG_W-1:0]         rows_a,
  input  logic [CFG_W-1:0]         inner_size,
  input  logic [CFG_W-1:0]         cols_b,
  input  logic                     item_valid,
  output logic                     item_stall,
  input  logic                     kind,
  input  logic [ELEMENT_WIDTH-1:0] value,
  output logic                     a_we,
  output logic                     b_we,
  output logic [ADDR_W-1:0]        a_waddr,
  output logic [ADDR_W-1:0]        b_waddr,
  output logic [ELEMENT_WIDTH-1:0] wdata,
  output logic                     job_push,
  output job_t                     job,
  input  logic                     job_ready,
  input  logic                     done
);

  localparam int CNT_W = $clog2(MAX_DIM * MAX_DIM + 1);

  logic [CFG_W-1:0]   m;
  logic [CFG_W-1:0]   n;
  logic [CFG_W-1:0]   p;
  logic [2*CFG_W-1:0] a_prod;
  logic [2*CFG_W-1:0] b_prod;
  logic [CNT_W-1:0]   a_size;
  logic [CNT_W-1:0]   b_size;
  logic [CNT_W-1:0]   a_count;
  logic [CNT_W-1:0]   b_count;
  logic [CNT_W-1:0]   a_count_next;
  logic [CNT_W-1:0]   b_count_next;
  logic               busy;
  logic               accept;
  logic               fire;

  function automatic logic [CFG_W-1:0] clamp_dim(input logic [CFG_W-1:0] r);
    logic [CFG_W-1:0] res;
    if (r == '0) begin
      res = CFG_W'(1);
    end else if (r > CFG_W'(MAX_DIM)) begin
      res = CFG_W'(MAX_DIM);
    end else begin
      res = r;
    end
    return res;
  endfunction

  assign m      = clamp_dim(rows_a);
  assign n      = clamp_dim(inner_size);
  assign p      = clamp_dim(cols_b);
  assign a_prod = m * n;
  assign b_prod = n * p;
  assign a_size = CNT_W'(a_prod);
  assign b_size = CNT_W'(b_prod);

  assign item_stall = busy || !job_ready;
  assign accept     = item_valid && !item_stall;

  // surplus elements are dropped
  assign a_we    = accept && (kind == KIND_A) && (a_count < a_size);
  assign b_we    = accept && (kind == KIND_B) && (b_count < b_size);
  assign a_waddr = a_count[ADDR_W-1:0];
  assign b_waddr = b_count[ADDR_W-1:0];
  assign wdata   = value;

  assign a_count_next = a_count + CNT_W'(a_we);
  assign b_count_next = b_count + CNT_W'(b_we);
  assign fire         = accept && (a_count_next >= a_size) && (b_count_next >= b_size);

  assign job_push = fire;
  assign job      = '{m: m, n: n, p: p};

  always_ff @(posedge clk) begin
    if (rst) begin
      a_count <= '0;
      b_count <= '0;
      busy    <= 1'b0;
    end else begin
      if (fire) begin
        a_count <= '0;
        b_count <= '0;
        busy    <= 1'b1;
      end else begin
        a_count <= a_count_next;
        b_count <= b_count_next;
        if (done) begin
          busy <= 1'b0;
        end
      end
    end
  end

endmodule

FILE: design/smm_back.sv
// compute back: walks the product, multiply-accumulates, holds the result item
`timescale 1ns / 1ps

module smm_back import smm_pkg::*; #(
  parameter int MAX_DIM       = MAX_DIM_DEF,
  parameter int ELEMENT_WIDTH = ELEM_W_DEF,
  parameter int ADDR_W        = (MAX_DIM * MAX_DIM > 1) ? $clog2(MAX_DIM * MAX_DIM) : 1
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        job_valid,
  input  job_t                        job_in,
  output logic                        job_pop,
  output logic                        rd_en,
  output logic [ADDR_W-1:0]           a_raddr,
  output logic [ADDR_W-1:0]           b_raddr,
  input  logic [ELEMENT_WIDTH-1:0]    a_rdata,
  input  logic [ELEMENT_WIDTH-1:0]    b_rdata,
  output logic                        result_valid,
  input  logic                        result_stall,
  output logic [IDX_W-1:0]            row,
  output logic [IDX_W-1:0]            col,
  output logic signed [PRODUCT_W-1:0] product,
  output logic                        last,
  output logic                        done
);

  localparam int PW   = 2 * ELEMENT_WIDTH;
  localparam int WIDE = (PW > PRODUCT_W) ? PW : PRODUCT_W;

  typedef enum logic [1:0] {IDLE, HOLD, ISSUE, WAIT} state_t;

  state_t               state;
  logic [CFG_W-1:0]     m;
  logic [CFG_W-1:0]     n;
  logic [CFG_W-1:0]     p;
  logic [CFG_W-1:0]     i;
  logic [CFG_W-1:0]     j;
  logic [CFG_W-1:0]     k;
  logic [ADDR_W-1:0]    a_base;
  logic [ADDR_W-1:0]    a_addr;
  logic [ADDR_W-1:0]    b_addr;
  logic                 s1_vld;
  logic                 s1_first;
  logic                 s1_lastk;
  logic                 s2_vld;
  logic                 s2_first;
  logic                 s2_lastk;
  logic signed [PW-1:0] s2_prod;
  logic signed [WIDE-1:0] prod_wide;
  logic [PRODUCT_W-1:0] acc;
  logic [PRODUCT_W-1:0] acc_next;
  logic                 out_free;
  logic                 k_last;
  logic                 elem_done;

  assign job_pop   = (state == IDLE) && job_valid;
  assign rd_en     = (state == ISSUE);
  assign a_raddr   = a_addr;
  assign b_raddr   = b_addr;
  assign out_free  = !result_valid || !result_stall;
  assign k_last    = (k == n - CFG_W'(1));
  assign prod_wide = WIDE'(s2_prod);
  assign acc_next  = (s2_first ? '0 : acc) + prod_wide[PRODUCT_W-1:0];
  assign elem_done = s2_vld && s2_lastk;

  // read, multiply and accumulate stages
  always_ff @(posedge clk) begin
    s1_first <= (k == '0);
    s1_lastk <= k_last;
    s2_first <= s1_first;
    s2_lastk <= s1_lastk;
    s2_prod  <= $signed(a_rdata) * $signed(b_rdata);
    if (s2_vld) begin
      acc <= acc_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= IDLE;
      s1_vld       <= 1'b0;
      s2_vld       <= 1'b0;
      result_valid <= 1'b0;
      done         <= 1'b0;
    end else begin
      done   <= 1'b0;
      s1_vld <= rd_en;
      s2_vld <= s1_vld;
      if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end
      if (elem_done) begin
        result_valid <= 1'b1;
        row          <= IDX_W'(i);
        col          <= IDX_W'(j);
        product      <= $signed(acc_next);
        last         <= (i == m - CFG_W'(1)) && (j == p - CFG_W'(1));
      end
      unique case (state)
        IDLE: begin
          if (job_valid) begin
            m      <= job_in.m;
            n      <= job_in.n;
            p      <= job_in.p;
            i      <= '0;
            j      <= '0;
            a_base <= '0;
            state  <= HOLD;
          end
        end
        HOLD: begin
          if (out_free) begin
            k      <= '0;
            a_addr <= a_base;
            b_addr <= ADDR_W'(j);
            state  <= ISSUE;
          end
        end
        ISSUE: begin
          k      <= k + CFG_W'(1);
          a_addr <= a_addr + ADDR_W'(1);
          b_addr <= b_addr + ADDR_W'(p);
          if (k_last) begin
            state <= WAIT;
          end
        end
        WAIT: begin
          if (elem_done) begin
            if (j == p - CFG_W'(1)) begin
              j <= '0;
              if (i == m - CFG_W'(1)) begin
                done  <= 1'b1;
                state <= IDLE;
              end else begin
                i      <= i + CFG_W'(1);
                a_base <= a_base + ADDR_W'(n);
                state  <= HOLD;
              end
            end else begin
              j     <= j + CFG_W'(1);
              state <= HOLD;
            end
          end
        end
      endcase
    end
  end

endmodule

FILE: verif/tb.sv
// self-checking testbench for the small signed matrix multiplier
`timescale 1ns / 1ps

module tb;
  import smm_pkg::*;

  localparam int ELEM_W        = ELEM_W_DEF;
  localparam int MAX_D         = MAX_DIM_DEF;
  localparam int STORE_N       = MAX_D * MAX_D;
  localparam int ITEMS         = 120;     // loaded elements in the random part
  localparam int SETTLE_CYCLES = 24;      // pause at the end of wait_drained
  localparam int END_CYCLES    = 40;
  localparam int CYCLE_LIMIT   = 4000000;
  localparam int LONG_HOLD     = 400;     // one long result hold-off, in cycles
  localparam int HOLD_AFTER    = 60;      // items accepted before the hold may start

  localparam logic signed [ELEM_W-1:0] V_MIN = {1'b1, {(ELEM_W-1){1'b0}}};
  localparam logic signed [ELEM_W-1:0] V_MAX = {1'b0, {(ELEM_W-1){1'b1}}};

  // one element item as offered on the input channel
  typedef struct packed {
    logic                     kind;
    logic signed [ELEM_W-1:0] value;
  } element_t;

  // one element of the product matrix
  typedef struct packed {
    logic [IDX_W-1:0]     row;
    logic [IDX_W-1:0]     col;
    logic [PRODUCT_W-1:0] product;
    logic                 last;
  } cell_t;

  // clock and reset
  logic clk = 1'b0;
  logic rst = 1'b1;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // block ports, all inputs known from time zero
  logic                    psel    = 1'b0;
  logic                    penable = 1'b0;
  logic                    pwrite  = 1'b0;
  logic [REG_ADDR_W-1:0]   paddr   = '0;
  logic [APB_DATA_W-1:0]   pwdata  = '0;
  logic [APB_DATA_W-1:0]   prdata;
  logic                    pready;
  logic                    item_valid = 1'b0;
  logic                    item_stall;
  logic                    kind  = KIND_A;
  logic signed [ELEM_W-1:0] value = '0;
  logic                    result_valid;
  logic                    result_stall = 1'b0;
  logic [IDX_W-1:0]        row;
  logic [IDX_W-1:0]        col;
  logic signed [PRODUCT_W-1:0] product;
  logic                    last;

  small_matrix_multiply i_dut (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .kind         (kind),
    .value        (value),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .row          (row),
    .col          (col),
    .product      (product),
    .last         (last)
  );

  // shared between the processes
  element_t elem_pending[$];   // elements waiting to be offered
  cell_t    due_cells[$];      // product elements predicted but not yet seen
  int       errors = 0;
  int       accepted_items = 0;
  int       cycles = 0;
  bit       send_calm = 1'b0;  // no gaps on the element side
  bit       recv_calm = 1'b0;  // no random stalls on the product side

  // predictor state: its own copy of the registers, counters and stores
  logic [CFG_W-1:0]         rows_a_cfg, inner_cfg, cols_b_cfg;
  logic signed [ELEM_W-1:0] a_elems [STORE_N];
  logic signed [ELEM_W-1:0] b_elems [STORE_N];
  int                       a_fill, b_fill;

  task automatic report_error(input string msg);
    if (errors < 100) $display("tb: mismatch at %0t: %s", $time, msg);
    errors++;
  endtask

  // register value as the block uses it: zero reads as one, big values saturate
  function automatic int dim_of(input logic [CFG_W-1:0] raw);
    if (raw == 0) return 1;
    if (raw > MAX_D) return MAX_D;
    return int'(raw);
  endfunction

  // gap length: mostly none, some short, a few long
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic signed [ELEM_W-1:0] rand_value();
    case ($urandom_range(0, 9))
      0:       return V_MIN;
      1:       return V_MAX;
      2:       return $urandom_range(0, 1) ? '1 : '0;
      default: return ELEM_W'($urandom());
    endcase
  endfunction

  // mostly small dimensions, now and then a large or over-range one
  function automatic logic [CFG_W-1:0] pick_dim();
    if ($urandom_range(0, 7) == 0) return CFG_W'($urandom_range(4, 15));
    return CFG_W'($urandom_range(0, 3));
  endfunction

  // store one accepted element and, once both matrices are full, predict the
  // whole product in row-major order and clear both counters
  task automatic take_element(input logic is_b, input logic signed [ELEM_W-1:0] v);
    int    m, n, p;
    longint acc;
    cell_t c;
    m = dim_of(rows_a_cfg);
    n = dim_of(inner_cfg);
    p = dim_of(cols_b_cfg);
    if (is_b == KIND_A) begin
      if (a_fill < m * n) begin
        a_elems[a_fill] = v;
        a_fill++;
      end
    end else if (b_fill < n * p) begin
      b_elems[b_fill] = v;
      b_fill++;
    end
    if (a_fill >= m * n && b_fill >= n * p) begin
      for (int i = 0; i < m; i++) begin
        for (int j = 0; j < p; j++) begin
          acc = 0;
          for (int x = 0; x < n; x++)
            acc += longint'(a_elems[i * n + x]) * longint'(b_elems[x * p + j]);
          c.row     = IDX_W'(i);
          c.col     = IDX_W'(j);
          c.product = acc[PRODUCT_W-1:0];
          c.last    = (i == m - 1) && (j == p - 1);
          due_cells.push_back(c);
        end
      end
      a_fill = 0;
      b_fill = 0;
    end
  endtask

  // ---------------------------------------------------------------------------
  // element driver: pops the pending queue, holds the payload while stalled and
  // leaves random gaps between items
  // ---------------------------------------------------------------------------
  element_t next_elem;
  int       send_gap = 0;

  always @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
      send_gap = 0;
    end else if (!item_valid || !item_stall) begin
      // the current item, if any, is accepted at this edge
      if (send_gap > 0) begin
        item_valid <= 1'b0;
        send_gap--;
      end else if (elem_pending.size() != 0) begin
        next_elem = elem_pending.pop_front();
        kind       <= next_elem.kind;
        value      <= next_elem.value;
        item_valid <= 1'b1;
        send_gap = send_calm ? 0 : pick_gap();
      end else begin
        item_valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // product-side stall: random stalls, plus one long hold-off while elements
  // are still pending so the block backs up and stalls its input
  // ---------------------------------------------------------------------------
  int stall_left = 0;
  int hold_left  = 0;
  bit hold_done  = 1'b0;

  always @(posedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
      stall_left = 0;
      hold_left  = 0;
    end else if (hold_left > 0) begin
      result_stall <= 1'b1;
      hold_left--;
    end else if (!hold_done && result_valid && accepted_items >= HOLD_AFTER &&
                 elem_pending.size() != 0) begin
      result_stall <= 1'b1;
      hold_left = LONG_HOLD - 1;
      hold_done = 1'b1;
    end else if (stall_left > 0) begin
      result_stall <= 1'b1;
      stall_left--;
    end else if (!recv_calm && $urandom_range(0, 3) == 0) begin
      result_stall <= 1'b1;
      stall_left = pick_gap();
    end else begin
      result_stall <= 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: follows register writes and accepted elements, predicts, and
  // checks every accepted product element against the oldest prediction
  // ---------------------------------------------------------------------------
  cell_t want;

  always @(posedge clk) begin
    if (rst) begin
      rows_a_cfg = 4'd1;
      inner_cfg  = 4'd1;
      cols_b_cfg = 4'd1;
      a_fill = 0;
      b_fill = 0;
    end else begin
      if (result_valid && !result_stall) begin
        if (due_cells.size() == 0) begin
          report_error($sformatf("product at row %0d col %0d with none due", row, col));
        end else begin
          want = due_cells.pop_front();
          if (row !== want.row)
            report_error($sformatf("row: got %0d, want %0d", row, want.row));
          if (col !== want.col)
            report_error($sformatf("col: got %0d, want %0d", col, want.col));
          if (product !== want.product)
            report_error($sformatf("product at %0d,%0d: got %0d, want %0d",
                                   want.row, want.col, product, $signed(want.product)));
          if (last !== want.last)
            report_error($sformatf("last at %0d,%0d: got %b, want %b",
                                   want.row, want.col, last, want.last));
        end
      end
      // only the low nibble of the write data is kept
      if (psel && penable && pwrite && pready) begin
        case (paddr[REG_ADDR_W-1:2])
          REG_ROWS_A:     rows_a_cfg = pwdata[CFG_W-1:0];
          REG_INNER_SIZE: inner_cfg  = pwdata[CFG_W-1:0];
          REG_COLS_B:     cols_b_cfg = pwdata[CFG_W-1:0];
          default: ;
        endcase
      end
      if (item_valid && !item_stall) begin
        take_element(kind, value);
        accepted_items++;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------
  task automatic offer(input logic k, input logic signed [ELEM_W-1:0] v);
    elem_pending.push_back('{k, v});
  endtask

  // setup then access phase; random bits above the nibble must be ignored
  task automatic write_reg(input logic [1:0] idx, input logic [CFG_W-1:0] val);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= REG_ADDR_W'({idx, 2'b00});
    pwdata  <= ($urandom() << CFG_W) | APB_DATA_W'(val);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic set_dims(input logic [CFG_W-1:0] r, input logic [CFG_W-1:0] n,
                          input logic [CFG_W-1:0] c);
    write_reg(REG_ROWS_A, r);
    write_reg(REG_INNER_SIZE, n);
    write_reg(REG_COLS_B, c);
  endtask

  // everything offered and accepted, every prediction seen, then a short pause
  // in case the block is still busy behind the last product
  task automatic wait_drained();
    while (elem_pending.size() != 0 || item_valid) @(posedge clk);
    while (due_cells.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin : stimulus
    int phase, jobs, na, nb, useful, m, n, p;
    logic [CFG_W-1:0] r_raw, n_raw, c_raw;

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // reset dimensions are 1 x 1 x 1: extreme corners, B ahead of A once
    offer(KIND_A, V_MIN);
    offer(KIND_B, V_MIN);
    offer(KIND_B, V_MAX);
    offer(KIND_A, V_MIN);
    wait_drained();

    // zero and over-range registers saturate to a 1 x 8 x 1 product; all
    // minimum elements give the largest magnitude sum, and one surplus A
    // element after A is full must be dropped
    set_dims(4'd0, 4'd9, 4'd0);
    repeat (4) offer(KIND_B, V_MIN);
    repeat (8) offer(KIND_A, V_MIN);
    offer(KIND_A, V_MAX);
    repeat (4) offer(KIND_B, V_MIN);
    wait_drained();

    // shrinking inner_size mid-load leaves both counters at or past their sizes, so
    // the next item fires even though it is itself a surplus element
    set_dims(4'd1, 4'd2, 4'd1);
    offer(KIND_A, 16'sd5);
    offer(KIND_A, -16'sd7);
    offer(KIND_B, 16'sd3);
    wait_drained();
    write_reg(REG_INNER_SIZE, 4'd1);
    offer(KIND_A, 16'sd100);

    // random phases: new dimensions, then whole matrix pairs with shuffled
    // interleaving, the odd surplus element and sometimes a ragged tail
    useful = 0;
    phase  = 0;
    while (useful < ITEMS) begin
      wait_drained();
      if (phase == 0) begin
        r_raw = 4'd15;   // widest product: 8 x 1 x 8
        n_raw = 4'd1;
        c_raw = 4'd8;
      end else begin
        r_raw = pick_dim();
        n_raw = pick_dim();
        c_raw = pick_dim();
      end
      set_dims(r_raw, n_raw, c_raw);
      m = dim_of(r_raw);
      n = dim_of(n_raw);
      p = dim_of(c_raw);
      send_calm = ($urandom_range(0, 3) == 0);
      recv_calm = ($urandom_range(0, 3) == 0);
      jobs = (m * n + n * p > 30) ? 1 : $urandom_range(1, 4);
      repeat (jobs) begin
        na = m * n;
        nb = n * p;
        useful += na + nb;
        while (na + nb > 0) begin
          if ($urandom_range(1, na + nb) <= na) begin
            offer(KIND_A, rand_value());
            na--;
          end else begin
            offer(KIND_B, rand_value());
            nb--;
          end
          // surplus element for the matrix that is already full
          if (na == 0 && nb > 0 && $urandom_range(0, 9) == 0)
            offer(KIND_A, rand_value());
          else if (nb == 0 && na > 0 && $urandom_range(0, 9) == 0)
            offer(KIND_B, rand_value());
        end
      end
      // broken sequence: a few elements of random kind left half loaded
      if ($urandom_range(0, 3) == 0)
        repeat ($urandom_range(2, 6))
          offer($urandom_range(0, 1) ? KIND_B : KIND_A, rand_value());
      phase++;
    end

    wait_drained();
    repeat (END_CYCLES) @(posedge clk);
    if (errors == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
